>>> rtl/signed_integer_to_radix_digits_assert.svh
// assertion macros for the radix digit printer
`ifndef SIGNED_INTEGER_TO_RADIX_DIGITS_ASSERT_SVH
`define SIGNED_INTEGER_TO_RADIX_DIGITS_ASSERT_SVH
`ifndef SYNTHESIS
// implication checked on every clock edge out of reset
`define SIRTD_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("sirtd assertion failed");
// condition that must never hold out of reset
`define SIRTD_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("sirtd forbidden condition");
`else
`define SIRTD_ASSERT(lbl, clk, rst_n, prop)
`define SIRTD_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

>>> rtl/sirtd_pkg.sv
// shared types, constants and helpers for the radix digit printer
`default_nettype none
package sirtd_pkg;

    localparam int MaxRadix   = 16;
    localparam int AlphaW     = 8;
    localparam int ValueW     = 32;
    localparam int DigitW     = $clog2(MaxRadix);
    localparam int RadixW     = 5;
    localparam int CfgW       = 64;
    localparam int StackDepth = ValueW;
    localparam int StackIdxW  = $clog2(StackDepth);
    localparam int CountW     = $clog2(StackDepth + 1);
    localparam int ChunkW     = 4;
    localparam int DivSteps   = ValueW / ChunkW;
    localparam int DivCntW    = $clog2(DivSteps);

    localparam logic [AlphaW-1:0] ChPlus  = 8'h2B;
    localparam logic [AlphaW-1:0] ChMinus = 8'h2D;
    localparam logic [AlphaW-1:0] ChLow   = 8'd32;
    localparam logic [AlphaW-1:0] ChHigh  = 8'd126;

    localparam logic [RadixW-1:0] RadixReset     = 5'd10;
    localparam logic [CfgW-1:0]   AlphaLowReset  = 64'h3736353433323130;
    localparam logic [CfgW-1:0]   AlphaHighReset = 64'h0000000000003938;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_RADIX      = 2'd0,
        CFG_ALPHA_LOW  = 2'd1,
        CFG_ALPHA_HIGH = 2'd2
    } t_cfg_index;

    // sixteen alphabet characters, character 0 in the low byte
    typedef logic [MaxRadix-1:0][AlphaW-1:0] t_alphabet;

    // result of the alphabet scan
    typedef struct packed {
        logic done;
        logic ok;
    } t_chk_res;

    // result of one division by the radix
    typedef struct packed {
        logic              done;
        logic [ValueW-1:0] quotient;
        logic [DigitW-1:0] remainder;
    } t_div_res;

    // printable and not a sign character
    function automatic logic f_char_ok(input logic [AlphaW-1:0] c);
        return (c != ChPlus) && (c != ChMinus) && (c >= ChLow) && (c <= ChHigh);
    endfunction

endpackage
`default_nettype wire

>>> rtl/sirtd_alpha_chk.sv
// alphabet validity scan, one character per cycle
`default_nettype none
module sirtd_alpha_chk (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_start,
    input  wire logic [4:0]               i_radix,
    input  wire sirtd_pkg::t_alphabet     i_alpha,
    output sirtd_pkg::t_chk_res           o_res
);
    import sirtd_pkg::*;

    typedef enum logic {C_IDLE, C_SCAN} t_state;

    t_state              r_state;
    logic [DigitW-1:0]   r_idx;
    logic                r_done;
    logic                r_ok;
    logic [AlphaW-1:0]   w_char;
    logic                w_dup;
    logic                w_bad;
    logic                w_last;

    // current character against range, signs and every later character in use
    always_comb begin
        w_char = i_alpha[r_idx];
        w_dup  = 1'b0;
        for (int j = 0; j < MaxRadix; j++) begin
            if ((RadixW'(j) > {1'b0, r_idx}) && (RadixW'(j) < i_radix)
                    && (i_alpha[j] == w_char)) begin
                w_dup = 1'b1;
            end
        end
        w_bad  = !f_char_ok(w_char) || w_dup;
        w_last = ({1'b0, r_idx} == (i_radix - 1'b1));
    end

    // scan sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_done  <= 1'b0;
            r_ok    <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                C_IDLE: begin
                    if (i_start) begin
                        if ((i_radix < RadixW'(2)) || (i_radix > RadixW'(MaxRadix))) begin
                            r_done <= 1'b1;
                            r_ok   <= 1'b0;
                        end else begin
                            r_idx   <= '0;
                            r_state <= C_SCAN;
                        end
                    end
                end
                C_SCAN: begin
                    if (w_bad) begin
                        r_done  <= 1'b1;
                        r_ok    <= 1'b0;
                        r_state <= C_IDLE;
                    end else if (w_last) begin
                        r_done  <= 1'b1;
                        r_ok    <= 1'b1;
                        r_state <= C_IDLE;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                default: r_state <= C_IDLE;
            endcase
        end
    end

    assign o_res.done = r_done;
    assign o_res.ok   = r_ok;

endmodule
`default_nettype wire

>>> rtl/sirtd_div_unit.sv
// divider reused for every digit: 32-bit value by the radix, four quotient bits per cycle
`default_nettype none
module sirtd_div_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [sirtd_pkg::ValueW-1:0]  i_dividend,
    input  wire logic [4:0]                    i_divisor,
    output sirtd_pkg::t_div_res                o_res
);
    import sirtd_pkg::*;

    logic                r_busy;
    logic                r_done;
    logic [DivCntW-1:0]  r_cnt;
    logic [ValueW-1:0]   r_quo;
    logic [DigitW-1:0]   r_rem;
    logic [DigitW-1:0]   n_rem;
    logic [ChunkW-1:0]   n_qbits;
    logic [RadixW-1:0]   w_trial;

    // restoring division over the top chunk of the shifting dividend
    always_comb begin
        n_rem   = r_rem;
        n_qbits = '0;
        w_trial = '0;
        for (int k = ChunkW - 1; k >= 0; k--) begin
            w_trial = {n_rem, r_quo[ValueW - ChunkW + k]};
            if (w_trial >= i_divisor) begin
                n_rem      = DigitW'(w_trial - i_divisor);
                n_qbits[k] = 1'b1;
            end else begin
                n_rem = w_trial[DigitW-1:0];
            end
        end
    end

    // step counter and shift registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DivCntW'(DivSteps - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
        end else if (r_busy) begin
            r_quo <= {r_quo[ValueW-ChunkW-1:0], n_qbits};
            r_rem <= n_rem;
        end
    end

    assign o_res.done      = r_done;
    assign o_res.quotient  = r_quo;
    assign o_res.remainder = r_rem;

endmodule
`default_nettype wire

>>> rtl/signed_integer_to_radix_digits.sv
// top level: signed 32-bit value to text in a configurable radix
`default_nettype none
`include "signed_integer_to_radix_digits_assert.svh"
// Prints each accepted signed value as ASCII text in base radix (2 to 16), using the
// alphabet held in alphabet_low/alphabet_high: a leading '-' for negative values, then
// digits most significant first, o_last set on the final character. The alphabet is
// scanned first, one character a cycle; if the radix is out of range or the alphabet
// holds a sign, a non-printable or a repeated character, the value produces no output.
// One value is worked on at a time and o_stall stays high until its last character has
// been loaded into the output register. Each digit then takes one pass of the divider,
// four quotient bits per cycle; a value has at most 32 digits (in base 2), and zero needs
// no division. Each character then leaves at one per cycle when the receiver does not
// stall. Configuration must be written while idle only; the block does not enforce
// this.
module signed_integer_to_radix_digits (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // configuration write port
    input  wire logic                          i_cfg_we,
    input  wire logic [1:0]                    i_cfg_index,
    input  wire logic [sirtd_pkg::CfgW-1:0]    i_cfg_data,
    // input channel
    input  wire logic                          i_valid,
    output      logic                          o_stall,
    input  wire logic [sirtd_pkg::ValueW-1:0]  i_value,
    // output channel
    output      logic                          o_valid,
    input  wire logic                          i_stall,
    output      logic [sirtd_pkg::AlphaW-1:0]  o_character,
    output      logic                          o_last
);
    import sirtd_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_DIV_GO,
        S_DIV,
        S_SIGN,
        S_DIGITS
    } t_state;

    t_state                r_state;
    logic [RadixW-1:0]     r_radix;
    t_alphabet             r_alpha;
    logic                  r_neg;
    logic [ValueW-1:0]     r_mag;
    logic [DigitW-1:0]     r_stack [StackDepth];
    logic [CountW-1:0]     r_cnt;
    logic                  r_out_valid;
    logic [AlphaW-1:0]     r_out_char;
    logic                  r_out_last;

    logic                  w_in_xfer;
    logic                  w_out_free;
    logic                  w_out_load;
    logic [CountW-1:0]     w_top;
    logic [DigitW-1:0]     w_digit;
    t_chk_res              w_chk;
    t_div_res              w_div;

    assign w_in_xfer  = i_valid && (r_state == S_IDLE);
    assign w_out_free = !r_out_valid || !i_stall;
    assign w_out_load = w_out_free && ((r_state == S_SIGN) || (r_state == S_DIGITS));
    assign w_top      = r_cnt - 1'b1;
    assign w_digit    = r_stack[w_top[StackIdxW-1:0]];

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix <= RadixReset;
            r_alpha <= {AlphaHighReset, AlphaLowReset};
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_RADIX:      r_radix      <= i_cfg_data[RadixW-1:0];
                CFG_ALPHA_LOW:  r_alpha[7:0]  <= i_cfg_data;
                CFG_ALPHA_HIGH: r_alpha[15:8] <= i_cfg_data;
                default:        ;
            endcase
        end
    end

    sirtd_alpha_chk u_chk (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_in_xfer),
        .i_radix (r_radix),
        .i_alpha (r_alpha),
        .o_res   (w_chk)
    );

    sirtd_div_unit u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == S_DIV_GO),
        .i_dividend (r_mag),
        .i_divisor  (r_radix),
        .o_res      (w_div)
    );

    // sequencer with digit stack and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_xfer) begin
                        r_neg   <= i_value[ValueW-1];
                        r_mag   <= i_value[ValueW-1] ? (ValueW'(0) - i_value) : i_value;
                        r_cnt   <= '0;
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (w_chk.done) begin
                        if (!w_chk.ok) begin
                            r_state <= S_IDLE;
                        end else if (r_mag == '0) begin
                            // zero prints as alphabet character 0
                            r_stack[0] <= '0;
                            r_cnt      <= CountW'(1);
                            r_state    <= r_neg ? S_SIGN : S_DIGITS;
                        end else begin
                            r_state <= S_DIV_GO;
                        end
                    end
                end
                S_DIV_GO: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (w_div.done) begin
                        r_stack[r_cnt[StackIdxW-1:0]] <= w_div.remainder;
                        r_cnt <= r_cnt + 1'b1;
                        r_mag <= w_div.quotient;
                        if (w_div.quotient == '0) begin
                            r_state <= r_neg ? S_SIGN : S_DIGITS;
                        end else begin
                            r_state <= S_DIV_GO;
                        end
                    end
                end
                S_SIGN: begin
                    if (w_out_free) begin
                        r_out_char  <= ChMinus;
                        r_out_last  <= 1'b0;
                        r_state     <= S_DIGITS;
                    end
                end
                S_DIGITS: begin
                    // pop most significant digit first
                    if (w_out_free) begin
                        r_out_char  <= r_alpha[w_digit];
                        r_out_last  <= (r_cnt == CountW'(1));
                        r_cnt       <= w_top;
                        if (r_cnt == CountW'(1)) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_stall     = (r_state != S_IDLE);
    assign o_valid     = r_out_valid;
    assign o_character = r_out_char;
    assign o_last      = r_out_last;

    // a transfer in closes the input until the last character is loaded for output
    `SIRTD_ASSERT(a_busy_after_in, i_clk, i_rst_n, (i_valid && !o_stall) |=> o_stall)
    // digit stack never overflows
    `SIRTD_NEVER(a_stack_bound, i_clk, i_rst_n, r_cnt > CountW'(StackDepth))
    // the final character is always a digit, never the sign
    `SIRTD_NEVER(a_last_not_sign, i_clk, i_rst_n, o_valid && o_last && (o_character == ChMinus))

endmodule
`default_nettype wire

>>> dv/radix_text_checker.sv
`timescale 1ns / 1ps
// checker for the radix digit printer: follows the configuration, works out each value's text and compares it
module radix_text_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [1:0]                   i_cfg_index,
    input  logic [sirtd_pkg::CfgW-1:0]   i_cfg_data,
    input  logic                         i_in_valid,
    input  logic                         i_in_stall,
    input  logic [sirtd_pkg::ValueW-1:0] i_in_value,
    input  logic                         i_out_valid,
    input  logic                         i_out_stall,
    input  logic [sirtd_pkg::AlphaW-1:0] i_out_character,
    input  logic                         i_out_last,
    output int                           o_mismatches,
    output int                           o_pending
);
    import sirtd_pkg::*;

    localparam int ReportLimit = 100;

    typedef struct packed {
        logic [AlphaW-1:0] ch;
        logic              last;
    } t_text_char;

    // own copy of the registers
    logic [RadixW-1:0] radix_reg;
    logic [CfgW-1:0]   alpha_low;
    logic [CfgW-1:0]   alpha_high;

    t_text_char expected_text[$];
    int         mismatch_count = 0;

    assign o_mismatches = mismatch_count;

    initial o_pending = 0;

    // one line per mismatch, printing capped so a dead block cannot flood the log
    task automatic report_mismatch(input string what);
        if (mismatch_count < ReportLimit) begin
            $display("[%0t] radix text mismatch: %s", $time, what);
        end
        mismatch_count++;
    endtask

    function automatic logic [AlphaW-1:0] char_at(input int pos);
        logic [2*CfgW-1:0] both;
        both = {alpha_high, alpha_low};
        return both[pos*AlphaW +: AlphaW];
    endfunction

    // base in range and the characters in use printable, unsigned and all different
    function automatic logic alphabet_valid();
        int               n;
        int               a;
        int               b;
        logic [AlphaW-1:0] c;
        n = int'(radix_reg);
        if (n < 2 || n > MaxRadix) begin
            return 1'b0;
        end
        for (a = 0; a < n; a++) begin
            c = char_at(a);
            if (c == ChPlus || c == ChMinus || c < ChLow || c > ChHigh) begin
                return 1'b0;
            end
            for (b = a + 1; b < n; b++) begin
                if (char_at(b) == c) begin
                    return 1'b0;
                end
            end
        end
        return 1'b1;
    endfunction

    // text of one value: optional minus, then digits most significant first
    function automatic void queue_text(input logic [ValueW-1:0] value);
        logic [ValueW-1:0] mag;
        logic [AlphaW-1:0] digits [ValueW];
        int                nd;
        int                k;
        if (!alphabet_valid()) begin
            return;
        end
        mag = value[ValueW-1] ? (32'd0 - value) : value;
        nd  = 0;
        // zero still gives one digit
        if (mag == 0) begin
            digits[0] = char_at(0);
            nd = 1;
        end
        while (mag != 0) begin
            digits[nd] = char_at(int'(mag % radix_reg));
            mag = mag / radix_reg;
            nd++;
        end
        if (value[ValueW-1]) begin
            expected_text.push_back(t_text_char'{ch: ChMinus, last: 1'b0});
        end
        for (k = nd - 1; k >= 0; k--) begin
            expected_text.push_back(t_text_char'{ch: digits[k], last: (k == 0)});
        end
    endfunction

    always @(posedge i_clk) begin
        t_text_char due;
        if (!i_rst_n) begin
            radix_reg  = RadixReset;
            alpha_low  = AlphaLowReset;
            alpha_high = AlphaHighReset;
            expected_text.delete();
        end else begin
            // output transfer against the oldest expected character
            if (i_out_valid === 1'b1 && i_out_stall === 1'b0) begin
                if (expected_text.size() == 0) begin
                    report_mismatch($sformatf("unexpected character 8'h%02h last %b",
                                              i_out_character, i_out_last));
                end else begin
                    due = expected_text.pop_front();
                    if (i_out_character !== due.ch) begin
                        report_mismatch($sformatf("character 8'h%02h, expected 8'h%02h",
                                                  i_out_character, due.ch));
                    end
                    if (i_out_last !== due.last) begin
                        report_mismatch($sformatf("last %b on character 8'h%02h, expected %b",
                                                  i_out_last, due.ch, due.last));
                    end
                end
            end
            // input transfer
            if (i_in_valid === 1'b1 && i_in_stall === 1'b0) begin
                queue_text(i_in_value);
            end
            // register writes
            if (i_cfg_we === 1'b1) begin
                case (t_cfg_index'(i_cfg_index))
                    CFG_RADIX:      radix_reg  = i_cfg_data[RadixW-1:0];
                    CFG_ALPHA_LOW:  alpha_low  = i_cfg_data;
                    CFG_ALPHA_HIGH: alpha_high = i_cfg_data;
                    default: ;
                endcase
            end
        end
        o_pending <= expected_text.size();
    end

endmodule

>>> dv/signed_integer_to_radix_digits_tb.sv
`timescale 1ns / 1ps
// testbench top for the radix digit printer: clock, reset, stimulus, configuration and verdict
module signed_integer_to_radix_digits_tb;
    import sirtd_pkg::*;

    localparam int ValueCount  = 350;
    // drain wait, about twice the longest single item before its first character
    localparam int DrainCycles = 2 * (1 + MaxRadix + 10 * ValueW);

    typedef enum {
        STALL_NONE,
        STALL_RANDOM,
        STALL_PERIODIC,
        STALL_HEAVY
    } t_stall_mode;

    typedef enum {
        FLAW_PLUS,
        FLAW_MINUS,
        FLAW_LOW_CHAR,
        FLAW_HIGH_CHAR,
        FLAW_REPEAT,
        FLAW_RADIX_LOW,
        FLAW_RADIX_HIGH
    } t_flaw;

    logic              clk;
    logic              rst_n     = 1'b0;
    logic              cfg_we    = 1'b0;
    t_cfg_index        cfg_index = CFG_RADIX;
    logic [CfgW-1:0]   cfg_data  = '0;
    logic              in_valid  = 1'b0;
    logic              in_stall;
    logic [ValueW-1:0] in_value  = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [AlphaW-1:0] out_char;
    logic              out_last;
    int                mismatches;
    int                pending;

    t_stall_mode stall_mode = STALL_NONE;
    int          stall_left = 0;
    int          burst_left = 1;
    int          sent_count = 0;

    signed_integer_to_radix_digits DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_valid     (in_valid),
        .o_stall     (in_stall),
        .i_value     (in_value),
        .o_valid     (out_valid),
        .i_stall     (out_stall),
        .o_character (out_char),
        .o_last      (out_last)
    );

    radix_text_checker text_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .i_in_stall      (in_stall),
        .i_in_value      (in_value),
        .i_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .i_out_character (out_char),
        .i_out_last      (out_last),
        .o_mismatches    (mismatches),
        .o_pending       (pending)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // receiver back-pressure: a mode held for a random stretch, then another
    always @(posedge clk) begin
        if (stall_left == 0) begin
            stall_mode <= t_stall_mode'($urandom_range(0, 3));
            stall_left <= $urandom_range(20, 200);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            STALL_NONE:     out_stall <= 1'b0;
            STALL_RANDOM:   out_stall <= ($urandom_range(0, 1) == 1);
            STALL_PERIODIC: out_stall <= ((stall_left % 8) < 5);
            default:        out_stall <= ($urandom_range(0, 3) != 0);
        endcase
    end

    // one transfer, then a gap when the current burst runs out
    task automatic send_value(input logic [ValueW-1:0] v);
        int gap;
        in_valid <= 1'b1;
        in_value <= v;
        do @(posedge clk); while (in_stall !== 1'b0);
        burst_left--;
        sent_count++;
        if (burst_left <= 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
                                                      : $urandom_range(1, 10);
        end
    endtask

    // hold the sender until every expected character is out, then linger
    task automatic settle(input int extra);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    // all three registers, written only once the block is quiet
    task automatic load_config(input logic [CfgW-1:0] rword, lo, hi);
        settle(DrainCycles);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_RADIX;
        cfg_data  <= rword;
        @(posedge clk);
        cfg_index <= CFG_ALPHA_LOW;
        cfg_data  <= lo;
        @(posedge clk);
        cfg_index <= CFG_ALPHA_HIGH;
        cfg_data  <= hi;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // sixteen distinct printable characters, no sign characters
    function automatic logic [2*CfgW-1:0] random_alphabet();
        logic [2*CfgW-1:0] a;
        logic [255:0]      used;
        logic [AlphaW-1:0] c;
        int                k;
        used          = '0;
        used[ChPlus]  = 1'b1;
        used[ChMinus] = 1'b1;
        for (k = 0; k < MaxRadix; k++) begin
            do c = 8'($urandom_range(32, 126)); while (used[c]);
            used[c] = 1'b1;
            a[k*AlphaW +: AlphaW] = c;
        end
        return a;
    endfunction

    // extremes, small values, values of random length and full-width values
    function automatic logic [ValueW-1:0] random_value();
        logic [ValueW-1:0] v;
        case ($urandom_range(0, 7))
            0: begin
                case ($urandom_range(0, 4))
                    0:       v = 32'd0;
                    1:       v = 32'd1;
                    2:       v = 32'hFFFF_FFFF;
                    3:       v = 32'h7FFF_FFFF;
                    default: v = 32'h8000_0000;
                endcase
            end
            1, 2: begin
                v = 32'($urandom_range(0, 300));
                if ($urandom_range(0, 1) == 1) v = 32'd0 - v;
            end
            3, 4: begin
                v = $urandom() >> $urandom_range(0, 31);
                if ($urandom_range(0, 1) == 1) v = 32'd0 - v;
            end
            default: v = $urandom();
        endcase
        return v;
    endfunction

    initial begin
        logic [2*CfgW-1:0] alpha;
        logic [CfgW-1:0]   rword;
        logic              flawed;
        int                radix;
        int                pos;
        int                other;
        int                n;
        int                k;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // reset setting: decimal
        send_value(32'd0);
        send_value(32'd1);
        send_value(32'hFFFF_FFFF);
        send_value(32'h7FFF_FFFF);
        send_value(32'h8000_0000);
        send_value(32'd1234567890);
        send_value(32'hFFFF_FFF6);

        // binary, longest text; spare radix bits and unused characters all ones
        load_config(64'hFFFF_FFFF_FFFF_FFE2, {48'hFFFF_FFFF_FFFF, "10"}, '1);
        send_value(32'h8000_0000);
        send_value(32'hFFFF_FFFF);
        send_value(32'h7FFF_FFFF);

        // base sixteen, alphabet starts with space and ends with tilde
        load_config(64'd16, "gfedcba ", "~zyxwvut");
        send_value(32'hDEAD_BEEF);
        send_value(32'd0);
        send_value(32'h8000_0000);

        // base three, characters past the radix left as zero bytes
        load_config(64'd3, {40'h0, "CBA"}, '0);
        send_value(32'hFFFF_FF85);
        send_value(32'd59048);

        // broken settings: nothing may come out
        load_config('0, AlphaLowReset, AlphaHighReset);
        send_value(32'd5);
        load_config(64'd1, AlphaLowReset, AlphaHighReset);
        send_value(32'd5);
        load_config(64'd17, "76543210", "FEDCBA98");
        send_value(32'd5);
        load_config('1, "76543210", "FEDCBA98");
        send_value(32'd5);
        load_config(64'd10, "7654+210", AlphaHighReset);
        send_value(32'd5);
        load_config(64'd12, "76543210", {32'h0, "-A98"});
        send_value(32'd5);
        load_config(64'd10, {"7654321", 8'h1F}, AlphaHighReset);
        send_value(32'd5);
        load_config(64'd10, AlphaLowReset, {48'h0, 8'h7F, "8"});
        send_value(32'd5);
        load_config(64'd16, "76543210", "0EDCBA98");
        send_value(32'd5);

        // random settings, each followed by a run of values
        while (sent_count < ValueCount) begin
            radix = $urandom_range(2, MaxRadix);
            alpha = random_alphabet();
            for (k = radix; k < MaxRadix; k++) begin
                alpha[k*AlphaW +: AlphaW] = 8'($urandom());
            end
            rword  = {32'($urandom()), 32'($urandom())};
            flawed = ($urandom_range(0, 7) == 0);
            if (flawed) begin
                pos = $urandom_range(0, radix - 1);
                case (t_flaw'($urandom_range(0, 6)))
                    FLAW_PLUS:      alpha[pos*AlphaW +: AlphaW] = ChPlus;
                    FLAW_MINUS:     alpha[pos*AlphaW +: AlphaW] = ChMinus;
                    FLAW_LOW_CHAR:  alpha[pos*AlphaW +: AlphaW] = 8'($urandom_range(0, 31));
                    FLAW_HIGH_CHAR: alpha[pos*AlphaW +: AlphaW] = 8'($urandom_range(127, 255));
                    FLAW_REPEAT: begin
                        other = (pos + $urandom_range(1, radix - 1)) % radix;
                        alpha[other*AlphaW +: AlphaW] = alpha[pos*AlphaW +: AlphaW];
                    end
                    FLAW_RADIX_LOW: radix = $urandom_range(0, 1);
                    default:        radix = $urandom_range(17, 31);
                endcase
            end
            rword[RadixW-1:0] = RadixW'(radix);
            load_config(rword, alpha[CfgW-1:0], alpha[2*CfgW-1:CfgW]);
            n = flawed ? $urandom_range(2, 5) : $urandom_range(15, 40);
            for (k = 0; k < n && sent_count < ValueCount; k++) begin
                // now and then let the block run dry mid-run
                if (!flawed && k == n / 2 && $urandom_range(0, 2) == 0) begin
                    settle(0);
                end
                send_value(random_value());
            end
        end

        settle(DrainCycles);
        if (mismatches == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // hang guard
    initial begin
        #20_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
